### sv/bbcd_pkg.sv
// ----------------------------------------------------------------------------
// Buffer cache directory package
// Shared widths, operation and status codes, and the types that pass between
// the directory cells and the controller.
// ----------------------------------------------------------------------------
package bbcd_pkg;

  // Directory geometry.
  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);

  // Field widths of the words on the channels.
  localparam int FUNC_W   = 2;
  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int SLOT_W   = 5;
  localparam int TICK_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Operation codes carried by the input word.
  localparam logic [FUNC_W-1:0] FN_GET     = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_PIN     = 2'd2;
  localparam logic [FUNC_W-1:0] FN_UNPIN   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ERR  = 2'd3;

  // Update commands broadcast to the cells.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
  localparam logic [OP_W-1:0] OP_HIT     = 3'd1;
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd2;
  localparam logic [OP_W-1:0] OP_PIN     = 3'd3;
  localparam logic [OP_W-1:0] OP_UNPIN   = 3'd4;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd5;

  // Search record handed from cell to cell during a get.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] fidx;
    logic             ffill;
    logic             have;
    logic [IDX_W-1:0] bidx;
    logic [TICK_W-1:0] btime;
  } rec_t;

  // Update command seen by every cell; only the addressed cell acts.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [TICK_W-1:0] now;
  } cmd_t;

endpackage

### sv/bbcd_cell.sv
// ----------------------------------------------------------------------------
// Buffer cache directory cell
// Holds one directory entry, merges it into the search record passing along
// the chain, and applies update commands addressed to it.
// ----------------------------------------------------------------------------
module bbcd_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bbcd_pkg::IDX_W-1:0] cell_idx,
  input  logic [bbcd_pkg::DEV_W-1:0] req_dev,
  input  logic [bbcd_pkg::BLK_W-1:0] req_blk,
  input  bbcd_pkg::rec_t             rec_i,
  output bbcd_pkg::rec_t             rec_o,
  input  bbcd_pkg::cmd_t             cmd,
  output logic                       zero_o
);

  logic [bbcd_pkg::DEV_W-1:0]  tag_dev_r, tag_dev_nxt;
  logic [bbcd_pkg::BLK_W-1:0]  tag_blk_r, tag_blk_nxt;
  logic [bbcd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [bbcd_pkg::TICK_W-1:0] time_r, time_nxt;
  logic                        filled_r, filled_nxt;
  bbcd_pkg::rec_t              rec_r, rec_nxt;

  logic match;
  logic free;
  logic take;

  assign zero_o = (cnt_r == '0);
  assign rec_o  = rec_r;

  // Merge this entry into the search record: first match wins, and the
  // oldest free entry wins with ties kept by the earlier cell.
  assign match = (tag_dev_r == req_dev) && (tag_blk_r == req_blk);
  assign free  = (cnt_r == '0);
  assign take  = free && (!rec_i.have || (time_r < rec_i.btime));

  always_comb begin
    rec_nxt = rec_i;
    if (rec_i.valid) begin
      if (!rec_i.found && match) begin
        rec_nxt.found = 1'b1;
        rec_nxt.fidx  = cell_idx;
        rec_nxt.ffill = filled_r;
      end
      if (take) begin
        rec_nxt.have  = 1'b1;
        rec_nxt.bidx  = cell_idx;
        rec_nxt.btime = time_r;
      end
    end
  end

  // Apply an update command when it addresses this cell.
  always_comb begin
    tag_dev_nxt = tag_dev_r;
    tag_blk_nxt = tag_blk_r;
    cnt_nxt     = cnt_r;
    time_nxt    = time_r;
    filled_nxt  = filled_r;
    if (cmd.idx == cell_idx) begin
      case (cmd.op)
        bbcd_pkg::OP_HIT: begin
          if (cnt_r != bbcd_pkg::CNT_MAX) cnt_nxt = cnt_r + 1'b1;
          filled_nxt = 1'b1;
        end
        bbcd_pkg::OP_ALLOC: begin
          tag_dev_nxt = cmd.dev;
          tag_blk_nxt = cmd.blk;
          cnt_nxt     = bbcd_pkg::CNT_W'(1);
          filled_nxt  = 1'b1;
        end
        bbcd_pkg::OP_PIN: begin
          if (cnt_r != bbcd_pkg::CNT_MAX) cnt_nxt = cnt_r + 1'b1;
        end
        bbcd_pkg::OP_UNPIN: begin
          cnt_nxt = cnt_r - 1'b1;
        end
        bbcd_pkg::OP_RELEASE: begin
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == bbcd_pkg::CNT_W'(1)) time_nxt = cmd.now;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_dev_r <= '0;
      tag_blk_r <= '0;
      cnt_r     <= '0;
      time_r    <= '0;
      filled_r  <= 1'b0;
      rec_r     <= '0;
    end else begin
      tag_dev_r <= tag_dev_nxt;
      tag_blk_r <= tag_blk_nxt;
      cnt_r     <= cnt_nxt;
      time_r    <= time_nxt;
      filled_r  <= filled_nxt;
      rec_r     <= rec_nxt;
    end
  end

endmodule

### sv/block_buffer_cache_directory_top.sv
// ----------------------------------------------------------------------------
// Buffer cache directory
// Directory of disk block buffers with reference counts and oldest-free
// replacement, built as a chain of entry cells and a small controller.
// ----------------------------------------------------------------------------
// Usage: each input word carries an operation in in_tuser (get, release, pin,
// unpin) and its arguments in in_tdata. Each accepted word yields exactly one
// result word on the out_ channel (status, entry index, fill request).
// A get launches a search record into the first of 32 entry cells; the record
// moves one cell per cycle, so the length of the chain sets the lookup time.
// The controller then registers the result and issues the update, and the
// result moves on into the output register. Release, pin and unpin address
// their entry directly, load their result registers when the word is taken
// and pass the result on to the output register. One word is in work at a
// time; a new word is taken once the previous result is in the output
// register. While the receiver stalls, the result waits in that register and
// the block can still accept and process one more word, whose result then
// waits until the register empties.
// Reset clears every entry (tags, counts, times, fill marks) and the channel
// state; a word can be taken at the first rising edge that sees reset released.
// ----------------------------------------------------------------------------
module block_buffer_cache_directory_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // func
  input  logic [79:0] in_tdata,   // device, block_number, slot, now_tick, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // status, slot_out, need_fill
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Unpacked input fields.
  logic [bbcd_pkg::FUNC_W-1:0] in_func;
  logic [bbcd_pkg::DEV_W-1:0]  in_device;
  logic [bbcd_pkg::BLK_W-1:0]  in_block_number;
  logic [bbcd_pkg::SLOT_W-1:0] in_slot;
  logic [bbcd_pkg::TICK_W-1:0] in_now_tick;

  assign in_func         = in_tuser;
  assign in_device       = in_tdata[7:0];
  assign in_block_number = in_tdata[39:8];
  assign in_slot         = in_tdata[44:40];
  assign in_now_tick     = in_tdata[76:45];

  logic [bbcd_pkg::DEV_W-1:0]    req_dev_r, req_dev_nxt;
  logic [bbcd_pkg::BLK_W-1:0]    req_blk_r, req_blk_nxt;
  logic                          launch_r, launch_nxt;
  bbcd_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [bbcd_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [bbcd_pkg::SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                          res_fill_r, res_fill_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_data_r, out_data_nxt;

  bbcd_pkg::rec_t                chain [bbcd_pkg::ENTRIES+1];
  logic [bbcd_pkg::ENTRIES-1:0]  zero_vec;
  bbcd_pkg::rec_t                rec_end;

  logic                          in_acc;
  logic                          out_load;
  logic [bbcd_pkg::IDX_W-1:0]    slot_idx;
  logic                          slot_bad;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_RESULT) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign rec_end    = chain[bbcd_pkg::ENTRIES];

  assign slot_idx = bbcd_pkg::IDX_W'(in_slot);
  assign slot_bad = ({1'b0, in_slot} >= (bbcd_pkg::SLOT_W+1)'(bbcd_pkg::ENTRIES));

  // Search record entering the first cell.
  assign chain[0] = '{valid: launch_r, default: '0};

  // Row of entry cells.
  for (genvar g = 0; g < bbcd_pkg::ENTRIES; g++) begin : g_cell
    bbcd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (bbcd_pkg::IDX_W'(g)),
      .req_dev  (req_dev_r),
      .req_blk  (req_blk_r),
      .rec_i    (chain[g]),
      .rec_o    (chain[g+1]),
      .cmd      (cmd_r),
      .zero_o   (zero_vec[g])
    );
  end

  // Controller: decode the input word, wait for the search, issue the update.
  always_comb begin
    state_nxt      = state_r;
    req_dev_nxt    = req_dev_r;
    req_blk_nxt    = req_blk_r;
    launch_nxt     = 1'b0;
    cmd_nxt        = cmd_r;
    cmd_nxt.op     = bbcd_pkg::OP_NONE;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_fill_nxt   = res_fill_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_slot_nxt = '0;
          res_fill_nxt = 1'b0;
          cmd_nxt.idx  = slot_idx;
          cmd_nxt.now  = in_now_tick;
          if (in_func == bbcd_pkg::FN_GET) begin
            req_dev_nxt = in_device;
            req_blk_nxt = in_block_number;
            launch_nxt  = 1'b1;
            state_nxt   = S_SCAN;
          end else begin
            state_nxt = S_RESULT;
            if (slot_bad) begin
              res_status_nxt = bbcd_pkg::ST_ERR;
            end else if (in_func == bbcd_pkg::FN_PIN) begin
              res_status_nxt = bbcd_pkg::ST_OK;
              cmd_nxt.op     = bbcd_pkg::OP_PIN;
            end else if (zero_vec[slot_idx]) begin
              res_status_nxt = bbcd_pkg::ST_ERR;
            end else begin
              res_status_nxt = bbcd_pkg::ST_OK;
              cmd_nxt.op     = (in_func == bbcd_pkg::FN_RELEASE) ?
                               bbcd_pkg::OP_RELEASE : bbcd_pkg::OP_UNPIN;
            end
          end
        end
      end
      S_SCAN: begin
        if (rec_end.valid) begin
          state_nxt   = S_RESULT;
          cmd_nxt.dev = req_dev_r;
          cmd_nxt.blk = req_blk_r;
          if (rec_end.found) begin
            cmd_nxt.op     = bbcd_pkg::OP_HIT;
            cmd_nxt.idx    = rec_end.fidx;
            res_status_nxt = bbcd_pkg::ST_OK;
            res_slot_nxt   = bbcd_pkg::SLOT_W'(rec_end.fidx);
            res_fill_nxt   = !rec_end.ffill;
          end else if (rec_end.have) begin
            cmd_nxt.op     = bbcd_pkg::OP_ALLOC;
            cmd_nxt.idx    = rec_end.bidx;
            res_status_nxt = bbcd_pkg::ST_MISS;
            res_slot_nxt   = bbcd_pkg::SLOT_W'(rec_end.bidx);
            res_fill_nxt   = 1'b1;
          end else begin
            res_status_nxt = bbcd_pkg::ST_FULL;
            res_slot_nxt   = '0;
            res_fill_nxt   = 1'b0;
          end
        end
      end
      S_RESULT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {res_fill_r, res_slot_r, res_status_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      cmd_r       <= '{op: bbcd_pkg::OP_NONE, default: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      cmd_r       <= cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_dev_r    <= req_dev_nxt;
    req_blk_r    <= req_blk_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_fill_r   <= res_fill_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

### tb/sv/bbcd_directory_checker.sv
// ----------------------------------------------------------------------------
// Buffer cache directory checker
// Watches both channels of the directory, keeps its own copy of every entry
// (tags, reference count, last-used stamp, fill mark), predicts the result
// word of each accepted input word and compares it with what comes out.
// ----------------------------------------------------------------------------
module bbcd_directory_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,   // func
  input  logic [79:0] in_tdata,   // device, block_number, slot, now_tick, zero fill
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // status, slot_out, need_fill
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          misses,
  output int          fulls,
  output int          count_errs
);

  // Bit positions of the fields in the input word.
  localparam int BLK_LSB  = bbcd_pkg::DEV_W;
  localparam int SLOT_LSB = BLK_LSB + bbcd_pkg::BLK_W;
  localparam int TICK_LSB = SLOT_LSB + bbcd_pkg::SLOT_W;

  // Result word, status in the lowest bits.
  typedef struct packed {
    logic                          need_fill;
    logic [bbcd_pkg::SLOT_W-1:0]   slot_out;
    logic [bbcd_pkg::STATUS_W-1:0] status;
  } dir_reply_t;

  // Shadow copy of the directory.
  logic [bbcd_pkg::DEV_W-1:0]  dir_dev    [bbcd_pkg::ENTRIES];
  logic [bbcd_pkg::BLK_W-1:0]  dir_blk    [bbcd_pkg::ENTRIES];
  logic [bbcd_pkg::CNT_W-1:0]  dir_refs   [bbcd_pkg::ENTRIES];
  logic [bbcd_pkg::TICK_W-1:0] dir_stamp  [bbcd_pkg::ENTRIES];
  logic                        dir_loaded [bbcd_pkg::ENTRIES];

  dir_reply_t replies_due[$];
  dir_reply_t want;
  dir_reply_t got;

  // Clear every entry, as the block does on reset.
  task automatic clear_directory();
    int e;
    for (e = 0; e < bbcd_pkg::ENTRIES; e++) begin
      dir_dev[e]    = '0;
      dir_blk[e]    = '0;
      dir_refs[e]   = '0;
      dir_stamp[e]  = '0;
      dir_loaded[e] = 1'b0;
    end
  endtask

  // Apply one operation to the shadow directory and return its result word.
  function automatic dir_reply_t directory_apply(
      input logic [bbcd_pkg::FUNC_W-1:0] fn,
      input logic [bbcd_pkg::DEV_W-1:0]  dev,
      input logic [bbcd_pkg::BLK_W-1:0]  blk,
      input logic [bbcd_pkg::SLOT_W-1:0] slot,
      input logic [bbcd_pkg::TICK_W-1:0] tick);
    dir_reply_t r;
    int i;
    int pick;
    r = '0;
    if (fn == bbcd_pkg::FN_GET) begin
      // Lowest matching entry wins.
      pick = -1;
      for (i = bbcd_pkg::ENTRIES - 1; i >= 0; i--) begin
        if (dir_dev[i] == dev && dir_blk[i] == blk) begin
          pick = i;
        end
      end
      if (pick >= 0) begin
        r.status = bbcd_pkg::ST_OK;
        if (dir_refs[pick] != bbcd_pkg::CNT_MAX) begin
          dir_refs[pick] = dir_refs[pick] + 1'b1;
        end
      end else begin
        // Oldest free entry, lowest index on equal stamps.
        for (i = 0; i < bbcd_pkg::ENTRIES; i++) begin
          if (dir_refs[i] == '0) begin
            if (pick < 0) begin
              pick = i;
            end else if (dir_stamp[i] < dir_stamp[pick]) begin
              pick = i;
            end
          end
        end
        if (pick < 0) begin
          r.status = bbcd_pkg::ST_FULL;
          return r;
        end
        dir_dev[pick]    = dev;
        dir_blk[pick]    = blk;
        dir_refs[pick]   = bbcd_pkg::CNT_W'(1);
        dir_loaded[pick] = 1'b0;
        r.status         = bbcd_pkg::ST_MISS;
      end
      r.slot_out       = bbcd_pkg::SLOT_W'(pick);
      r.need_fill      = !dir_loaded[pick];
      dir_loaded[pick] = 1'b1;
    end else if (slot >= bbcd_pkg::ENTRIES) begin
      r.status = bbcd_pkg::ST_ERR;
    end else if (fn == bbcd_pkg::FN_PIN) begin
      if (dir_refs[slot] != bbcd_pkg::CNT_MAX) begin
        dir_refs[slot] = dir_refs[slot] + 1'b1;
      end
      r.status = bbcd_pkg::ST_OK;
    end else if (dir_refs[slot] == '0) begin
      // Release or unpin of an unused entry is refused.
      r.status = bbcd_pkg::ST_ERR;
    end else begin
      dir_refs[slot] = dir_refs[slot] - 1'b1;
      if (fn == bbcd_pkg::FN_RELEASE && dir_refs[slot] == '0) begin
        dir_stamp[slot] = tick;
      end
      r.status = bbcd_pkg::ST_OK;
    end
    return r;
  endfunction

  // Count a failure; only the first few are described.
  task automatic report_fault(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] directory mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      report_fault($sformatf("result %0d field %s expected %0d got %0d",
                             checked, name, exp_v, act_v));
    end
  endtask

  // Compare results first, then record the new input word, so that a result
  // can never be matched against a word accepted at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_directory();
      replies_due.delete();
      fail_count = 0;
      checked    = 0;
      misses     = 0;
      fulls      = 0;
      count_errs = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = dir_reply_t'(out_tdata);
        checked++;
        if (replies_due.size() == 0) begin
          report_fault($sformatf("result word %h with no word outstanding", out_tdata));
        end else begin
          want = replies_due.pop_front();
          compare_field("status", want.status, got.status);
          compare_field("slot_out", want.slot_out, got.slot_out);
          compare_field("need_fill", want.need_fill, got.need_fill);
          case (want.status)
            bbcd_pkg::ST_MISS: misses++;
            bbcd_pkg::ST_FULL: fulls++;
            bbcd_pkg::ST_ERR:  count_errs++;
            default: ;
          endcase
        end
      end
      if (in_tvalid && in_tready) begin
        replies_due.push_back(directory_apply(in_tuser,
                                              in_tdata[BLK_LSB-1:0],
                                              in_tdata[SLOT_LSB-1:BLK_LSB],
                                              in_tdata[TICK_LSB-1:SLOT_LSB],
                                              in_tdata[TICK_LSB+bbcd_pkg::TICK_W-1:TICK_LSB]));
      end
    end
    pending = replies_due.size();
  end

endmodule

### tb/sv/block_buffer_cache_directory_top_tb.sv
// ----------------------------------------------------------------------------
// Buffer cache directory testbench
// Drives get, release, pin and unpin words into the directory: a directed
// opening, a count saturation run, then random phases that fill, exhaust and
// drain the directory, with random idling on both channels and one long
// output stall. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module block_buffer_cache_directory_top_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // func
  logic [79:0] in_tdata;   // device, block_number, slot, now_tick, zero fill
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // status, slot_out, need_fill

  int fail_count;
  int pending;
  int checked;
  int misses;
  int fulls;
  int count_errs;

  // Stimulus state: no idling near the end, one long stall request.
  bit calm;
  bit hold_long;
  logic [bbcd_pkg::TICK_W-1:0] tick_base;
  logic [bbcd_pkg::TICK_W-1:0] tie_tick;
  logic [bbcd_pkg::DEV_W-1:0]  pool_dev [16];
  logic [bbcd_pkg::BLK_W-1:0]  pool_blk [16];

  // Entries the stimulus believes it holds references on, learned from results.
  logic [bbcd_pkg::SLOT_W-1:0] held[$];
  logic [bbcd_pkg::FUNC_W-1:0] issued_fn[$];
  logic [bbcd_pkg::FUNC_W-1:0] done_fn;

  block_buffer_cache_directory_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bbcd_directory_checker dir_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .misses     (misses),
    .fulls      (fulls),
    .count_errs (count_errs)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #6000000;
    $display("Timeout with %0d result words still outstanding.", pending);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stall bursts, plus one long stall to back the block up.
  initial begin
    int n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Track which entries gets handed out, so releases mostly name real ones.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        issued_fn.push_back(in_tuser);
      end
      if (out_tvalid && out_tready && issued_fn.size() > 0) begin
        done_fn = issued_fn.pop_front();
        if (done_fn == bbcd_pkg::FN_GET && (out_tdata[1:0] == bbcd_pkg::ST_OK ||
                                            out_tdata[1:0] == bbcd_pkg::ST_MISS)) begin
          held.push_back(out_tdata[6:2]);
        end
      end
    end
  end

  // Time stamps: mostly rising, with extremes, ties and random jumps.
  function automatic logic [bbcd_pkg::TICK_W-1:0] next_tick();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2, 3:    return tie_tick;
      4:       return $urandom;
      default: begin
        tick_base = tick_base + $urandom_range(1, 500);
        return tick_base;
      end
    endcase
  endfunction

  // Offer one word and wait until it is taken.
  task automatic put_word(input logic [bbcd_pkg::FUNC_W-1:0] fn,
                          input logic [bbcd_pkg::DEV_W-1:0]  dev,
                          input logic [bbcd_pkg::BLK_W-1:0]  blk,
                          input logic [bbcd_pkg::SLOT_W-1:0] slot,
                          input logic [bbcd_pkg::TICK_W-1:0] tick);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= fn;
    in_tdata  <= {3'b000, tick, slot, blk, dev};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Directed get; the unused slot and stamp carry random bits.
  task automatic get_tag(input logic [bbcd_pkg::DEV_W-1:0] dev,
                         input logic [bbcd_pkg::BLK_W-1:0] blk);
    put_word(bbcd_pkg::FN_GET, dev, blk, bbcd_pkg::SLOT_W'($urandom), $urandom);
  endtask

  // Directed release, pin or unpin; the unused tag carries random bits.
  task automatic slot_op(input logic [bbcd_pkg::FUNC_W-1:0] fn,
                         input logic [bbcd_pkg::SLOT_W-1:0] slot,
                         input logic [bbcd_pkg::TICK_W-1:0] tick);
    put_word(fn, bbcd_pkg::DEV_W'($urandom), $urandom, slot, tick);
  endtask

  // Random mix; get_pct sets how hard the phase pushes toward a full directory.
  task automatic run_mix(input int count, input int get_pct);
    int n;
    int r;
    int idx;
    logic [bbcd_pkg::FUNC_W-1:0] fn;
    logic [bbcd_pkg::DEV_W-1:0]  dev;
    logic [bbcd_pkg::BLK_W-1:0]  blk;
    logic [bbcd_pkg::SLOT_W-1:0] slot;
    for (n = 0; n < count; n++) begin
      r    = $urandom_range(0, 99);
      slot = bbcd_pkg::SLOT_W'($urandom_range(0, bbcd_pkg::ENTRIES - 1));
      dev  = bbcd_pkg::DEV_W'($urandom);
      blk  = $urandom;
      if (r < get_pct) begin
        fn = bbcd_pkg::FN_GET;
        r  = $urandom_range(0, 19);
        if (r < 12) begin
          idx = $urandom_range(0, 15);
          dev = pool_dev[idx];
          blk = pool_blk[idx];
        end else if (r < 17) begin
          // Fresh tag, remembered so later gets may hit it.
          idx = $urandom_range(0, 15);
          pool_dev[idx] = dev;
          pool_blk[idx] = blk;
        end else if (r == 17) begin
          dev = '0;
          blk = '0;
        end else if (r == 18) begin
          dev = '1;
          blk = '1;
        end else begin
          dev = '0;
          blk = '1;
        end
      end else begin
        r  = $urandom_range(0, 9);
        fn = (r < 6) ? bbcd_pkg::FN_RELEASE :
             ((r < 8) ? bbcd_pkg::FN_UNPIN : bbcd_pkg::FN_PIN);
        // Mostly drop or add a reference we hold; otherwise hit any entry.
        if (held.size() > 0 && $urandom_range(0, 9) != 0) begin
          idx  = $urandom_range(0, held.size() - 1);
          slot = held[idx];
          if (fn == bbcd_pkg::FN_PIN) begin
            held.push_back(slot);
          end else begin
            held.delete(idx);
          end
        end
      end
      put_word(fn, dev, blk, slot, next_tick());
    end
  endtask

  // Main stimulus.
  initial begin
    int i;
    in_tvalid <= 1'b0;
    in_tuser  <= bbcd_pkg::FN_GET;
    in_tdata  <= '0;
    rst_n     <= 1'b0;
    calm      = 1'b0;
    hold_long = 1'b0;
    tick_base = 1000;
    tie_tick  = $urandom;
    for (i = 0; i < 16; i++) begin
      pool_dev[i] = bbcd_pkg::DEV_W'($urandom);
      pool_blk[i] = $urandom;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Unallocated entries carry tag zero: first get hits entry 0 and asks for a fill.
    get_tag('0, '0);
    get_tag('0, '0);
    // Misses take the lowest free entry while all stamps are equal.
    get_tag('1, '1);
    get_tag('0, 1);
    get_tag('1, '0);
    // Underflow on unused entries, then a pin and unpin on one.
    slot_op(bbcd_pkg::FN_RELEASE, 31, $urandom);
    slot_op(bbcd_pkg::FN_UNPIN, 30, $urandom);
    slot_op(bbcd_pkg::FN_PIN, 31, $urandom);
    slot_op(bbcd_pkg::FN_UNPIN, 31, $urandom);
    // Stamp extremes; the next miss must pick the stamp-zero entry at index 2.
    slot_op(bbcd_pkg::FN_RELEASE, 1, '1);
    slot_op(bbcd_pkg::FN_RELEASE, 2, '0);
    slot_op(bbcd_pkg::FN_RELEASE, 3, 5);
    get_tag(7, 12345);
    // A released entry keeps its tag and is hit without a new fill.
    get_tag('1, '1);
    slot_op(bbcd_pkg::FN_PIN, 0, $urandom);
    slot_op(bbcd_pkg::FN_UNPIN, 0, $urandom);
    slot_op(bbcd_pkg::FN_RELEASE, 0, 100);
    slot_op(bbcd_pkg::FN_RELEASE, 0, 200);
    get_tag('0, '0);
    get_tag(1, '0);
    slot_op(bbcd_pkg::FN_UNPIN, 4, $urandom);
    get_tag(1, '0);

    // Saturation: entry 0 holds tag zero; drive its count past the top by pins
    // and hits, then release it all the way down into underflow.
    for (i = 0; i < 130; i++) slot_op(bbcd_pkg::FN_PIN, 0, next_tick());
    for (i = 0; i < 130; i++) get_tag('0, '0);
    for (i = 0; i < 5; i++) slot_op(bbcd_pkg::FN_PIN, 0, next_tick());
    for (i = 0; i < 257; i++) slot_op(bbcd_pkg::FN_RELEASE, 0, next_tick());

    // Random phases: balanced under a long output stall, fill up, drain, settle.
    hold_long = 1'b1;
    run_mix(300, 50);
    run_mix(250, 85);
    run_mix(250, 20);
    run_mix(50, 50);
    calm = 1'b1;
    run_mix(200, 50);
    in_tvalid <= 1'b0;

    // Let every outstanding result drain, then watch for strays.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Checked %0d result words: %0d misses, %0d full-directory refusals,",
             checked, misses, fulls);
    $display("%0d count errors, with saturation, stamp ties and a long output stall.",
             count_errs);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
